// ===== design/sfp_pkg.sv =====
package sfp_pkg;

   localparam int MAX_LEN       = 1024;
   localparam int NUM_LETTERS   = 26;
   localparam int ADDR_W        = $clog2(MAX_LEN);
   localparam int LEN_W         = 11;
   localparam int VALUE_W       = 10;
   localparam int LETTER_W      = 5;
   localparam int ERR_W         = 2;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [ERR_W-1:0]    err_type;

   localparam err_type ERR_OK      = 2'd0;
   localparam err_type ERR_NO_FREE = 2'd1;
   localparam err_type ERR_TOO_BIG = 2'd2;
   localparam err_type ERR_TOO_LONG = 2'd3;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      value_type  value;
      letter_type letter;
   } store_wr_type;

endpackage

// ===== design/sfp_stores.sv =====
module sfp_stores (
   input  logic                 clock,
   input  sfp_pkg::store_wr_type wr,
   input  sfp_pkg::addr_type    prefix_rd_addr,
   input  sfp_pkg::addr_type    letter_rd_addr,
   output sfp_pkg::value_type   prefix_rd_data,
   output sfp_pkg::letter_type  letter_rd_data
);
   import sfp_pkg::*;

   value_type  prefix_mem [MAX_LEN];
   letter_type letter_mem [MAX_LEN];
   value_type  prefix_rd_ff;
   letter_type letter_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         prefix_mem[wr.addr] <= wr.value;
         letter_mem[wr.addr] <= wr.letter;
      end
      prefix_rd_ff <= prefix_mem[prefix_rd_addr];
      letter_rd_ff <= letter_mem[letter_rd_addr];
   end

   assign prefix_rd_data = prefix_rd_ff;
   assign letter_rd_data = letter_rd_ff;

endmodule

// ===== design/string_from_prefix_function_top.sv =====
// path to rsp_valid: an error or position 0 goes from S_IDLE straight to S_DONE,
// a copy from an earlier letter goes through S_COPY, and a zero value goes through
// S_START, S_LINK and S_RESOLVE, walking the prefix chain at one store read per link.
// one item at a time: req_ready is high only in S_IDLE, so the next beat waits until
// the last result has left S_DONE, later while a result still waits in the output register.
// synchronous reset clears the length to zero and empties the result register;
// the stores are not cleared and are only read below the current length.
module string_from_prefix_function_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sfp_pkg::value_type   req_prefix_value,
   input  logic                 req_last_of_string,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfp_pkg::letter_type  rsp_letter,
   output sfp_pkg::err_type     rsp_error_code
);
   import sfp_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_START   = 3'd1;
   localparam logic [2:0] S_LINK    = 3'd2;
   localparam logic [2:0] S_COPY    = 3'd3;
   localparam logic [2:0] S_RESOLVE = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   logic [2:0]               state_ff, state_in;
   len_type                  len_ff, len_in;
   value_type                value_ff, value_in;
   logic                     last_ff, last_in;
   addr_type                 p_ff, p_in;
   logic [NUM_LETTERS-1:0]   forbid_ff, forbid_in;
   letter_type               res_letter_ff, res_letter_in;
   err_type                  res_err_ff, res_err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   letter_type               rsp_letter_ff, rsp_letter_in;
   err_type                  rsp_err_ff, rsp_err_in;

   store_wr_type wr;
   addr_type     prefix_rd_addr, letter_rd_addr;
   value_type    prefix_rd_data;
   letter_type   letter_rd_data;

   logic       accept, out_free, free_found;
   letter_type free_idx;
   addr_type   pos_addr;
   addr_type   next_p;

   sfp_stores u_stores (
      .clock          (clock),
      .wr             (wr),
      .prefix_rd_addr (prefix_rd_addr),
      .letter_rd_addr (letter_rd_addr),
      .prefix_rd_data (prefix_rd_data),
      .letter_rd_data (letter_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pos_addr  = len_ff[ADDR_W-1:0];
   assign next_p    = prefix_rd_data[ADDR_W-1:0];

   // smallest letter not yet forbidden
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = NUM_LETTERS - 1; k >= 0; k--) begin
         if (!forbid_ff[k]) begin
            free_found = 1'b1;
            free_idx   = LETTER_W'(k);
         end
      end
   end

   // read addresses: in idle set up for a copy or the first chain link,
   // in the walk follow the prefix value that has just come back
   always_comb begin
      if (state_ff == S_IDLE) begin
         letter_rd_addr = ADDR_W'(req_prefix_value - VALUE_W'(1));
         prefix_rd_addr = pos_addr - ADDR_W'(1);
      end else begin
         letter_rd_addr = next_p;
         prefix_rd_addr = next_p - ADDR_W'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      p_in          = p_ff;
      forbid_in     = forbid_ff;
      res_letter_in = res_letter_ff;
      res_err_in    = res_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_letter_in = rsp_letter_ff;
      rsp_err_in    = rsp_err_ff;
      wr.en         = 1'b0;
      wr.addr       = pos_addr;
      wr.value      = value_ff;
      wr.letter     = res_letter_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in      = req_prefix_value;
               last_in       = req_last_of_string;
               res_letter_in = '0;
               res_err_in    = ERR_OK;
               forbid_in     = '0;
               if (len_ff >= LEN_W'(MAX_LEN)) begin
                  res_err_in = ERR_TOO_LONG;
                  state_in   = S_DONE;
               end else if ({1'b0, req_prefix_value} > len_ff) begin
                  res_err_in = ERR_TOO_BIG;
                  state_in   = S_DONE;
               end else if (req_prefix_value != '0) begin
                  state_in = S_COPY;
               end else if (len_ff != '0) begin
                  state_in = S_START;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_COPY: begin
            res_letter_in = letter_rd_data;
            state_in      = S_DONE;
         end
         S_START: begin
            p_in     = next_p;
            state_in = S_LINK;
         end
         S_LINK: begin
            for (int k = 0; k < NUM_LETTERS; k++) begin
               if (letter_rd_data == LETTER_W'(k)) forbid_in[k] = 1'b1;
            end
            if (p_ff == '0) begin
               state_in = S_RESOLVE;
            end else begin
               p_in = next_p;
            end
         end
         S_RESOLVE: begin
            if (free_found) begin
               res_letter_in = free_idx;
            end else begin
               res_letter_in = '0;
               res_err_in    = ERR_NO_FREE;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = res_letter_ff;
               rsp_err_in    = res_err_ff;
               if (res_err_ff == ERR_OK) begin
                  wr.en  = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end
               if (last_ff) len_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff      <= value_in;
      last_ff       <= last_in;
      p_ff          <= p_in;
      forbid_ff     <= forbid_in;
      res_letter_ff <= res_letter_in;
      res_err_ff    <= res_err_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_letter     = rsp_letter_ff;
   assign rsp_error_code = rsp_err_ff;

   // the chain only moves to strictly earlier positions
   a_chain_descends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK && state_in == S_LINK) |=> (p_ff < $past(p_ff)))
      else $error("prefix chain did not descend");

   a_error_letter_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_OK) |-> (rsp_letter == '0))
      else $error("error result with nonzero letter");

   a_letter_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_letter < LETTER_W'(NUM_LETTERS)))
      else $error("letter out of alphabet");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("string length beyond store depth");

   a_store_write_ok: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_DONE && res_err_ff == ERR_OK && len_ff < LEN_W'(MAX_LEN)))
      else $error("store written outside a good commit");

endmodule
